@@ hdl/u16r_pkg.sv @@
// ----------------------------------------------------------------------------
// u16r_pkg
// Shared types and constants for the 16550-style UART register model.
// ----------------------------------------------------------------------------
package u16r_pkg;

  localparam int unsigned DEF_RX_FIFO_DEPTH = 16;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RECV  = 2'd2;

  localparam logic [1:0] KIND_NOP   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_RECV  = 2'd3;

  localparam logic [2:0] OFF_RBR = 3'd0;
  localparam logic [2:0] OFF_IER = 3'd1;
  localparam logic [2:0] OFF_IIR = 3'd2;
  localparam logic [2:0] OFF_LCR = 3'd3;
  localparam logic [2:0] OFF_MCR = 3'd4;
  localparam logic [2:0] OFF_LSR = 3'd5;
  localparam logic [2:0] OFF_MSR = 3'd6;
  localparam logic [2:0] OFF_SCR = 3'd7;

  localparam logic [7:0] IIR_NONE = 8'h01;
  localparam logic [7:0] IIR_THRE = 8'h02;
  localparam logic [7:0] IIR_RDA  = 8'h04;
  localparam logic [7:0] IIR_LSR  = 8'h06;

  localparam logic [7:0] LSR_FIXED   = 8'h60;
  localparam logic [7:0] LSR_ERR_MSK = 8'h1E;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] offset;
    logic [7:0] data;
  } cmd_t;

endpackage

@@ hdl/u16r_front.sv @@
// ----------------------------------------------------------------------------
// u16r_front
// Accepts input items, classifies them into commands and holds them in a
// two-entry queue for the execution stage.
// ----------------------------------------------------------------------------
module u16r_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [1:0]      in_tuser,
  input  logic [23:0]     in_tdata,
  output logic            q_valid,
  output u16r_pkg::cmd_t  q_cmd,
  input  logic            q_pop
);
  import u16r_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_in.offset = in_tdata[2:0];
    case (in_tuser)
      OP_READ: begin
        cmd_in.kind = KIND_READ;
        cmd_in.data = 8'h00;
      end
      OP_WRITE: begin
        cmd_in.kind = KIND_WRITE;
        cmd_in.data = in_tdata[10:3];
      end
      OP_RECV: begin
        cmd_in.kind = KIND_RECV;
        cmd_in.data = in_tdata[18:11];
      end
      default: begin
        cmd_in.kind = KIND_NOP;
        cmd_in.data = 8'h00;
      end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_cmd     = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ hdl/u16r_back.sv @@
// ----------------------------------------------------------------------------
// u16r_back
// Executes queued commands against the UART registers and the receive FIFO,
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module u16r_back #(
  parameter int unsigned RX_FIFO_DEPTH = u16r_pkg::DEF_RX_FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  u16r_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [23:0]     out_tdata
);
  import u16r_pkg::*;

  localparam int unsigned PTR_W = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RX_FIFO_DEPTH + 1);

  logic [7:0]       mem [RX_FIFO_DEPTH];
  logic [7:0]       mem_q_r;

  logic [7:0]       lcr_r, lcr_nxt;
  logic [3:0]       ier_r, ier_nxt;
  logic [7:0]       iir_r, iir_nxt;
  logic [7:0]       mcr_r, mcr_nxt;
  logic             dr_r, dr_nxt;
  logic [7:0]       scr_r, scr_nxt;
  logic [15:0]      div_r, div_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             ov_r;
  logic [7:0]       rd_r, rd_nxt;
  logic             use_mem_r, use_mem_nxt;
  logic             txv_r, txv_nxt;
  logic [7:0]       txb_r, txb_nxt;
  logic             irq_r;
  logic             drop_r, drop_nxt;

  logic             adv;
  logic             exec;
  logic             dlab;
  logic             fifo_full;
  logic             fifo_empty;
  logic             push;
  logic             pop;
  logic [7:0]       lsr;
  logic [7:0]       iir_calc;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;

  assign adv        = !ov_r || out_tready;
  assign exec       = q_valid && adv;
  assign q_pop      = exec;
  assign dlab       = lcr_r[7];
  assign fifo_full  = (cnt_r == CNT_W'(RX_FIFO_DEPTH));
  assign fifo_empty = (cnt_r == '0);
  assign lsr        = LSR_FIXED | {7'd0, dr_r};
  assign head_inc   = (head_r == PTR_W'(RX_FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc   = (tail_r == PTR_W'(RX_FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  always_comb begin
    if (q_cmd.data[1] && lsr[5]) begin
      iir_calc = IIR_THRE;
    end else if (q_cmd.data[0] && lsr[0]) begin
      iir_calc = IIR_RDA;
    end else if (q_cmd.data[2] && ((lsr & LSR_ERR_MSK) != 8'h00)) begin
      iir_calc = IIR_LSR;
    end else begin
      iir_calc = IIR_NONE;
    end
  end

  always_comb begin
    lcr_nxt     = lcr_r;
    ier_nxt     = ier_r;
    iir_nxt     = iir_r;
    mcr_nxt     = mcr_r;
    dr_nxt      = dr_r;
    scr_nxt     = scr_r;
    div_nxt     = div_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    rd_nxt      = 8'h00;
    use_mem_nxt = 1'b0;
    txv_nxt     = 1'b0;
    txb_nxt     = 8'h00;
    drop_nxt    = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    if (exec) begin
      case (q_cmd.kind)
        KIND_READ: begin
          case (q_cmd.offset)
            OFF_RBR: begin
              if (dlab) begin
                rd_nxt = div_r[7:0];
              end else if (!fifo_empty) begin
                pop         = 1'b1;
                use_mem_nxt = 1'b1;
                head_nxt    = head_inc;
                cnt_nxt     = cnt_r - 1'b1;
                if (cnt_r == CNT_W'(1)) begin
                  dr_nxt = 1'b0;
                end
              end
            end
            OFF_IER: rd_nxt = dlab ? div_r[15:8] : {4'd0, ier_r};
            OFF_IIR: rd_nxt = iir_r;
            OFF_LCR: rd_nxt = lcr_r;
            OFF_MCR: rd_nxt = mcr_r;
            OFF_LSR: rd_nxt = lsr;
            OFF_MSR: rd_nxt = 8'h00;
            default: rd_nxt = scr_r;
          endcase
        end
        KIND_WRITE: begin
          case (q_cmd.offset)
            OFF_RBR: begin
              if (dlab) begin
                div_nxt = {div_r[15:8], q_cmd.data};
              end else begin
                txv_nxt = 1'b1;
                txb_nxt = q_cmd.data;
                iir_nxt = IIR_THRE;
              end
            end
            OFF_IER: begin
              if (dlab) begin
                div_nxt = {q_cmd.data, div_r[7:0]};
              end else begin
                ier_nxt = q_cmd.data[3:0];
                iir_nxt = iir_calc;
              end
            end
            OFF_LCR: lcr_nxt = q_cmd.data;
            OFF_MCR: mcr_nxt = q_cmd.data;
            OFF_SCR: scr_nxt = q_cmd.data;
            default: ;
          endcase
        end
        KIND_RECV: begin
          if (fifo_full) begin
            drop_nxt = 1'b1;
          end else begin
            push     = 1'b1;
            tail_nxt = tail_inc;
            cnt_nxt  = cnt_r + 1'b1;
            dr_nxt   = 1'b1;
            if (ier_r[0]) begin
              iir_nxt = IIR_RDA;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcr_r  <= 8'h00;
      ier_r  <= 4'h0;
      iir_r  <= IIR_NONE;
      mcr_r  <= 8'h00;
      dr_r   <= 1'b0;
      scr_r  <= 8'h00;
      div_r  <= 16'h0001;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      lcr_r  <= lcr_nxt;
      ier_r  <= ier_nxt;
      iir_r  <= iir_nxt;
      mcr_r  <= mcr_nxt;
      dr_r   <= dr_nxt;
      scr_r  <= scr_nxt;
      div_r  <= div_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      if (adv) begin
        ov_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rd_r      <= rd_nxt;
      use_mem_r <= use_mem_nxt;
      txv_r     <= txv_nxt;
      txb_r     <= txb_nxt;
      irq_r     <= !iir_nxt[0];
      drop_r    <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= q_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mem_q_r <= mem[head_r];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, drop_r, irq_r, txb_r, txv_r, use_mem_r ? mem_q_r : rd_r};

endmodule

@@ hdl/uart_16550_register_model.sv @@
// ----------------------------------------------------------------------------
// uart_16550_register_model
// Register model of a 16550-style UART with a receive FIFO.
// ----------------------------------------------------------------------------
// Each item is a bus read, a bus write, one received byte or an unused op,
// and gives exactly one result item. The block sustains one item per clock
// cycle while the output is not stalled; each item waits in the input queue
// and its result is registered in the output register. The rate is set by
// the execution stage, which updates the registers and the receive FIFO
// memory for one item per cycle; a two-entry input queue lets the input side
// keep accepting until it is full while a result waits on the output. The
// receive FIFO holds RX_FIFO_DEPTH bytes and needs no clearing after reset.
module uart_16550_register_model #(
  parameter int unsigned RX_FIFO_DEPTH = u16r_pkg::DEF_RX_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // op
  input  logic [23:0] in_tdata,   // reg_offset, write_data, rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // read_data, tx_valid, tx_byte, irq_pending, rx_dropped
);
  import u16r_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  u16r_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  u16r_back #(
    .RX_FIFO_DEPTH (RX_FIFO_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the 16550-style UART register model.
// Bus reads, bus writes and received bytes are driven on the input stream
// and every result is compared against a cycle-free model of the registers
// and receive FIFO kept here. A short directed sequence is followed by
// random traffic shaped around FIFO fill and drain, divisor latch access
// and interrupt enable changes, under three patterns of back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u16r_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned FIFO_DEPTH = DEF_RX_FIFO_DEPTH;
  localparam int unsigned PHASE_ITEMS = 367;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned QUEUE_DEPTH = 2048;

  typedef struct {
    logic [1:0] op;
    logic [2:0] offset;
    logic [7:0] wdata;
    logic [7:0] rx_byte;
  } uart_access_t;

  typedef struct packed {
    logic       rx_dropped;
    logic       irq_pending;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] read_data;
  } uart_response_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  uart_access_t   access_store[QUEUE_DEPTH];
  int unsigned    access_wr = 0;
  int unsigned    access_rd = 0;
  uart_response_t expected_store[QUEUE_DEPTH];
  int unsigned    expect_wr = 0;
  int unsigned    expect_rd = 0;
  uart_access_t   next_access;
  logic           in_took = 1'b0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_reads = 0;
  int unsigned n_writes = 0;
  int unsigned n_received = 0;
  int unsigned n_dropped = 0;
  int unsigned n_sent = 0;
  int unsigned n_unused = 0;

  logic [7:0]  shadow_lcr;
  logic [3:0]  shadow_ier;
  logic [7:0]  shadow_iir;
  logic [7:0]  shadow_mcr;
  logic [7:0]  shadow_lsr;
  logic [7:0]  shadow_scr;
  logic [7:0]  shadow_fcr;
  logic [15:0] shadow_divisor;
  logic [7:0]  shadow_fifo[FIFO_DEPTH];
  int unsigned fifo_count;
  int unsigned fifo_head;

  uart_16550_register_model dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void reset_shadow_regs();
    shadow_lcr = '0;
    shadow_ier = '0;
    shadow_iir = IIR_NONE;
    shadow_mcr = '0;
    shadow_lsr = LSR_FIXED;
    shadow_scr = '0;
    shadow_fcr = '0;
    shadow_divisor = 16'd1;
    fifo_count = 0;
    fifo_head = 0;
  endfunction

  function automatic void update_ident();
    if (shadow_ier[1] && shadow_lsr[5]) begin
      shadow_iir = IIR_THRE;
    end else if (shadow_ier[0] && shadow_lsr[0]) begin
      shadow_iir = IIR_RDA;
    end else if (shadow_ier[2] && ((shadow_lsr & LSR_ERR_MSK) != 0)) begin
      shadow_iir = IIR_LSR;
    end else begin
      shadow_iir = IIR_NONE;
    end
  endfunction

  function automatic uart_response_t predict_uart_response(uart_access_t a);
    uart_response_t r;
    logic dlab;
    r = '0;
    dlab = shadow_lcr[7];
    case (a.op)
      OP_READ: begin
        case (a.offset)
          OFF_RBR: begin
            if (dlab) begin
              r.read_data = shadow_divisor[7:0];
            end else if (fifo_count > 0) begin
              r.read_data = shadow_fifo[fifo_head];
              fifo_head = (fifo_head + 1) % FIFO_DEPTH;
              fifo_count--;
              if (fifo_count == 0) shadow_lsr[0] = 1'b0;
            end
          end
          OFF_IER: r.read_data = dlab ? shadow_divisor[15:8] : {4'b0, shadow_ier};
          OFF_IIR: r.read_data = shadow_iir;
          OFF_LCR: r.read_data = shadow_lcr;
          OFF_MCR: r.read_data = shadow_mcr;
          OFF_LSR: r.read_data = shadow_lsr;
          OFF_MSR: r.read_data = '0;
          default: r.read_data = shadow_scr;
        endcase
      end
      OP_WRITE: begin
        case (a.offset)
          OFF_RBR: begin
            if (dlab) begin
              shadow_divisor[7:0] = a.wdata;
            end else begin
              r.tx_valid = 1'b1;
              r.tx_byte = a.wdata;
              shadow_lsr = shadow_lsr | LSR_FIXED;
              shadow_iir = IIR_THRE;
            end
          end
          OFF_IER: begin
            if (dlab) begin
              shadow_divisor[15:8] = a.wdata;
            end else begin
              shadow_ier = a.wdata[3:0];
              update_ident();
            end
          end
          OFF_IIR: shadow_fcr = a.wdata;
          OFF_LCR: shadow_lcr = a.wdata;
          OFF_MCR: shadow_mcr = a.wdata;
          OFF_SCR: shadow_scr = a.wdata;
          default: ;
        endcase
      end
      OP_RECV: begin
        if (fifo_count >= FIFO_DEPTH) begin
          r.rx_dropped = 1'b1;
        end else begin
          shadow_fifo[(fifo_head + fifo_count) % FIFO_DEPTH] = a.rx_byte;
          fifo_count++;
          shadow_lsr[0] = 1'b1;
          if (shadow_ier[0]) shadow_iir = IIR_RDA;
        end
      end
      default: ;
    endcase
    r.irq_pending = ~shadow_iir[0];
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Input items are presented at the falling edge and held until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (access_wr != access_rd && $urandom_range(99) >= tx_idle_pct) begin
        next_access = access_store[access_rd % QUEUE_DEPTH];
        access_rd++;
        in_tuser <= next_access.op;
        in_tdata <= {5'b0, next_access.rx_byte, next_access.wdata, next_access.offset};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    uart_access_t   a;
    uart_response_t want;
    uart_response_t got;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        a.op = in_tuser;
        a.offset = in_tdata[2:0];
        a.wdata = in_tdata[10:3];
        a.rx_byte = in_tdata[18:11];
        want = predict_uart_response(a);
        expected_store[expect_wr % QUEUE_DEPTH] = want;
        expect_wr++;
        accepted_count++;
        case (a.op)
          OP_READ:  n_reads++;
          OP_WRITE: n_writes++;
          OP_RECV:  n_received++;
          default:  n_unused++;
        endcase
        if (want.rx_dropped) n_dropped++;
        if (want.tx_valid) n_sent++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[18:0];
        if (expect_wr == expect_rd) begin
          $error("Result item arrived with no expectation waiting: 0x%0h", out_tdata);
          error_count++;
        end else begin
          want = expected_store[expect_rd % QUEUE_DEPTH];
          expect_rd++;
          compare_field("read_data", want.read_data, got.read_data);
          compare_field("tx_valid", want.tx_valid, got.tx_valid);
          compare_field("tx_byte", want.tx_byte, got.tx_byte);
          compare_field("irq_pending", want.irq_pending, got.irq_pending);
          compare_field("rx_dropped", want.rx_dropped, got.rx_dropped);
          checked_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Stream stalled for %0d cycles.", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_access(logic [1:0] op, logic [2:0] offset, logic [7:0] wdata,
                              logic [7:0] rx_byte);
    uart_access_t a;
    a.op = op;
    a.offset = offset;
    a.wdata = wdata;
    a.rx_byte = rx_byte;
    access_store[access_wr % QUEUE_DEPTH] = a;
    access_wr++;
    issued_count++;
  endtask

  task automatic queue_directed();
    queue_access(OP_READ, OFF_IIR, 8'h00, 8'h00);
    queue_access(OP_READ, OFF_LSR, 8'h00, 8'h00);
    queue_access(OP_READ, OFF_RBR, 8'h00, 8'h00);
    queue_access(OP_WRITE, OFF_SCR, 8'hFF, 8'h00);
    queue_access(OP_READ, OFF_SCR, 8'h00, 8'h00);
    queue_access(OP_WRITE, OFF_RBR, 8'h00, 8'h00);
    queue_access(OP_WRITE, OFF_IER, 8'hFF, 8'hFF);
    queue_access(OP_WRITE, OFF_IER, 8'h01, 8'h00);
    queue_access(OP_RECV, OFF_SCR, 8'h00, 8'hA5);
    queue_access(OP_READ, OFF_LSR, 8'h00, 8'h00);
    queue_access(OP_READ, OFF_RBR, 8'h00, 8'h00);
    queue_access(OP_WRITE, OFF_IER, 8'h04, 8'h00);
    queue_access(OP_WRITE, OFF_LCR, 8'h80, 8'h00);
    queue_access(OP_WRITE, OFF_RBR, 8'hFF, 8'h00);
    queue_access(OP_WRITE, OFF_IER, 8'hFF, 8'h00);
    queue_access(OP_READ, OFF_RBR, 8'h00, 8'h00);
    queue_access(OP_READ, OFF_IER, 8'h00, 8'h00);
    queue_access(OP_WRITE, OFF_LCR, 8'h00, 8'h00);
    queue_access(OP_WRITE, OFF_IIR, 8'hC7, 8'h00);
    queue_access(OP_WRITE, OFF_MCR, 8'hFF, 8'h00);
    queue_access(OP_READ, OFF_MCR, 8'h00, 8'h00);
    queue_access(OP_WRITE, OFF_LSR, 8'hFF, 8'hFF);
    queue_access(OP_WRITE, OFF_MSR, 8'h5A, 8'h00);
    queue_access(OP_READ, OFF_MSR, 8'h00, 8'h00);
    queue_access(OP_UNUSED, OFF_SCR, 8'hFF, 8'hFF);
  endtask

  // Bursts of received bytes and RBR reads fill and drain the FIFO, and
  // divisor sequences open and close the latch around their accesses.
  task automatic queue_random_scenario();
    int unsigned pick;
    int unsigned n;
    logic [1:0]  op;
    logic [2:0]  offset;
    logic [7:0]  wdata;
    pick = $urandom_range(99);
    if (pick < 15) begin
      n = $urandom_range(20, 1);
      repeat (n) queue_access(OP_RECV, 3'($urandom_range(7)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
    end else if (pick < 27) begin
      n = $urandom_range(18, 1);
      repeat (n) queue_access(OP_READ, OFF_RBR, 8'($urandom_range(255)),
                              8'($urandom_range(255)));
    end else if (pick < 35) begin
      queue_access(OP_WRITE, OFF_LCR, 8'(8'h80 | $urandom_range(127)),
                   8'($urandom_range(255)));
      n = $urandom_range(4, 1);
      repeat (n) queue_access($urandom_range(1) ? OP_WRITE : OP_READ,
                              $urandom_range(1) ? OFF_IER : OFF_RBR,
                              8'($urandom_range(255)), 8'($urandom_range(255)));
      queue_access(OP_WRITE, OFF_LCR, 8'($urandom_range(127)), 8'($urandom_range(255)));
    end else if (pick < 42) begin
      queue_access(OP_WRITE, OFF_IER, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end else begin
      pick = $urandom_range(99);
      op = (pick < 35) ? OP_READ : (pick < 70) ? OP_WRITE : (pick < 94) ? OP_RECV : OP_UNUSED;
      offset = 3'($urandom_range(7));
      wdata = 8'($urandom_range(255));
      if (op == OP_WRITE && offset == OFF_LCR && $urandom_range(3) != 0) wdata[7] = 1'b0;
      queue_access(op, offset, wdata, 8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(int unsigned sender_idle, int unsigned receiver_idle);
    int unsigned target;
    tx_idle_pct = sender_idle;
    rx_idle_pct = receiver_idle;
    target = issued_count + PHASE_ITEMS;
    while (issued_count < target) queue_random_scenario();
    while (access_wr != access_rd) @(posedge clk);
  endtask

  initial begin
    reset_shadow_regs();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 23;
    rx_idle_pct = 64;
    queue_directed();
    run_phase(23, 64);
    run_phase(64, 23);
    run_phase(0, 0);
    while (accepted_count < issued_count || expect_wr != expect_rd) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expect_wr != expect_rd) begin
      $error("%0d expected result items never arrived", expect_wr - expect_rd);
      error_count++;
    end
    $display("Checked %0d results: %0d reads, %0d writes, %0d received bytes, %0d unused-op items.",
             checked_count, n_reads, n_writes, n_received, n_unused);
    $display("Receive FIFO overflowed %0d times; %0d bytes were transmitted.",
             n_dropped, n_sent);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ uart_16550_register_model.f @@
hdl/u16r_pkg.sv
hdl/u16r_front.sv
hdl/u16r_back.sv
hdl/uart_16550_register_model.sv
tb/sv/testbench.sv
